>>> rtl/core/fnsw_pkg.sv
`timescale 1ns / 1ps

package fnsw_pkg;

    // Width of the window length register as written over the configuration port
    localparam int CFG_W = 7;

    // Result flag carried in m_tuser
    localparam logic FOUND_NONE = 1'b0;
    localparam logic FOUND_NEG  = 1'b1;

endpackage

>>> rtl/core/fnsw_ram.sv
`timescale 1ns / 1ps

module fnsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data (old data on a collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/first_negative_in_sliding_window.sv
`timescale 1ns / 1ps
// Latency: a result appears on m_tdata/m_tuser in the cycle after its sample transfer.
// Throughput: one sample per cycle unless the output stalls or a register write is offered; both memories are read
// ahead of the next sample (queue head and oldest window sign), with a one-entry forward from the write port.
// Reset clears the window length to 1 and all pointers and counts; the sample queue and
// the sign history memories are not cleared and are only read where written before.
module first_negative_in_sliding_window #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write: window_len
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fnsw_pkg::CFG_W-1:0]            cfg_data,
    // sample stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,  // sample
    input  logic                                  s_tlast,  // last_sample
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,  // first_negative
    output logic                                  m_tuser   // found
);

    import fnsw_pkg::*;

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;
    localparam int TW = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // Clamp the written length into 1..WINDOW_MAX
    function automatic logic [LW-1:0] eff_len(input logic [CFG_W-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w == '0)
            return LW'(1);
        else if (w > CW'(WINDOW_MAX))
            return LW'(WINDOW_MAX);
        else
            return LW'(w);
    endfunction

    // Advance an index around the ring
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        return (x == AW'(WINDOW_MAX - 1)) ? '0 : x + 1'b1;
    endfunction

    // Slot of the oldest sample in a window of k ending at ptr
    function automatic logic [AW-1:0] oldest_slot(input logic [AW-1:0] ptr,
                                                  input logic [LW-1:0] k);
        logic [LW:0] t;
        t = (LW+1)'(ptr) + (LW+1)'(WINDOW_MAX) + (LW+1)'(1) - (LW+1)'(k);
        if (t >= (LW+1)'(WINDOW_MAX))
            t = t - (LW+1)'(WINDOW_MAX);
        return AW'(t);
    endfunction

    // Control state
    logic [LW-1:0]           k_reg, k_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [LW-1:0]           count_reg, count_next;
    logic [AW-1:0]           ptr_reg, ptr_next;
    logic [LW-1:0]           fill_reg, fill_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;
    logic                    out_found_reg, out_found_next;

    // Forwarding of the last write into the prefetched reads
    logic                    hist_hit_reg, q_hit_reg;
    logic                    hist_fwd_reg;
    logic [SAMPLE_WIDTH-1:0] q_fwd_reg;

    // Memory ports
    logic                    hist_we, q_we;
    logic [AW-1:0]           hist_raddr, q_raddr, q_waddr;
    logic [0:0]              hist_rdata;
    logic [SAMPLE_WIDTH-1:0] q_rdata;

    // Per-sample decode
    logic                    in_fire, cfg_fire;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    cur_neg, push, full, oldest_neg, pop;
    logic [SAMPLE_WIDTH-1:0] head_val;
    logic [LW-1:0]           count_pushed;
    logic [LW:0]             tail_sum;

    // Hold samples off while a register write is offered
    assign cfg_ready = 1'b1;
    assign s_tready  = (!out_valid_reg || m_tready) && !cfg_valid;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign sample  = s_tdata[SAMPLE_WIDTH-1:0];
    assign cur_neg = sample[SAMPLE_WIDTH-1];
    assign push    = cur_neg && (count_reg < LW'(WINDOW_MAX));
    assign full    = ((LW+1)'(fill_reg) + (LW+1)'(1)) >= (LW+1)'(k_reg);

    assign count_pushed = count_reg + LW'(push);

    // Queue tail: head plus count around the ring
    assign tail_sum = (LW+1)'(head_reg) + (LW+1)'(count_reg);
    assign q_waddr  = (tail_sum >= (LW+1)'(WINDOW_MAX))
                    ? AW'(tail_sum - (LW+1)'(WINDOW_MAX)) : AW'(tail_sum);

    // Resolve prefetched data against the previous cycle's write
    assign head_val   = q_hit_reg ? q_fwd_reg : q_rdata;
    assign oldest_neg = (k_reg == LW'(1)) ? cur_neg
                      : (hist_hit_reg ? hist_fwd_reg : hist_rdata[0]);
    assign pop        = full && oldest_neg && (count_pushed != '0);

    assign hist_we = in_fire && !cfg_fire;
    assign q_we    = hist_we && push;

    // Next state for pointers, counts and the output register
    always_comb
    begin
        k_next         = k_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_found_next = out_found_reg;

        if (cfg_fire)
        begin
            k_next     = eff_len(cfg_data);
            head_next  = '0;
            count_next = '0;
            ptr_next   = '0;
            fill_next  = '0;
        end
        else if (in_fire)
        begin
            if (full)
            begin
                out_valid_next = 1'b1;
                if (count_reg != '0)
                begin
                    out_data_next  = head_val;
                    out_found_next = FOUND_NEG;
                end
                else if (cur_neg)
                begin
                    out_data_next  = sample;
                    out_found_next = FOUND_NEG;
                end
                else
                begin
                    out_data_next  = '0;
                    out_found_next = FOUND_NONE;
                end
                fill_next = k_reg - LW'(1);
            end
            else
            begin
                fill_next = fill_reg + LW'(1);
            end

            head_next  = pop ? wrap_inc(head_reg) : head_reg;
            count_next = count_pushed - LW'(pop);
            ptr_next   = wrap_inc(ptr_reg);

            if (s_tlast)
            begin
                head_next  = '0;
                count_next = '0;
                ptr_next   = '0;
                fill_next  = '0;
            end
        end
    end

    // Prefetch addresses for whatever sample comes next
    assign q_raddr    = head_next;
    assign hist_raddr = oldest_slot(ptr_next, k_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= LW'(1);
            head_reg      <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            hist_hit_reg  <= 1'b0;
            q_hit_reg     <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            hist_hit_reg  <= hist_we && (ptr_reg == hist_raddr);
            q_hit_reg     <= q_we && (q_waddr == q_raddr);
        end
    end

    // Hold payload and forwarded write data
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_found_reg <= out_found_next;
        hist_fwd_reg  <= cur_neg;
        q_fwd_reg     <= sample;
    end

    fnsw_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (sample),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    fnsw_ram #(
        .WIDTH (1),
        .DEPTH (WINDOW_MAX)
    ) u_sign_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (ptr_reg),
        .wdata (cur_neg),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TW'(out_data_reg);
    assign m_tuser  = out_found_reg;

    // The queue never holds more negatives than samples in the window
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= fill_reg)
        else $error("negative queue larger than window contents");

    // A found result carries a negative sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[SAMPLE_WIDTH-1])
        else $error("found result is not negative");

    // No negative in the window gives zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("empty result is not zero");

    // The last sample of an array clears the stream state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_fire && s_tlast) |=>
            (fill_reg == '0 && count_reg == '0 && ptr_reg == '0 && head_reg == '0))
        else $error("stream state not cleared after last sample");

endmodule
